// ----- hw/rtl/dds_tuning_word_serial_loader_core_defines.svh -----
// Assertion helpers shared by the loader RTL.
`ifndef DDS_TUNING_WORD_SERIAL_LOADER_CORE_DEFINES_SVH
`define DDS_TUNING_WORD_SERIAL_LOADER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTWSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTWSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dtwsl_pkg.sv -----
`default_nettype none

package dtwsl_pkg;

	// Field widths.
	localparam int VALUE_BITS = 32;
	localparam int WORD_BITS  = 32;
	localparam int REF_W      = 31;
	localparam int CTRL_W     = 8;
	localparam int CFG_IDX_W  = 2;

	// Divider pipeline: one quotient bit per step, a few steps per stage.
	localparam int DIV_STEPS       = VALUE_BITS + WORD_BITS;
	localparam int STEP_SEL_W      = 2;
	localparam int STEPS_PER_STAGE = 1 << STEP_SEL_W;
	localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int STAGE_IDX_W     = (DIV_STAGES > 1) ? $clog2(DIV_STAGES) : 1;
	localparam int STEP_IDX_W      = STAGE_IDX_W + STEP_SEL_W;

	// Serial run: data bits, then one closing strobe.
	localparam int SR_W    = VALUE_BITS + CTRL_W;
	localparam int RUN_LEN = SR_W + 1;
	localparam int CNT_W   = $clog2(RUN_LEN);

	localparam logic [REF_W-1:0]  REF_CLOCK_RESET = REF_W'(125000000);
	localparam logic [CTRL_W-1:0] CONTROL_RESET   = 8'h00;
	localparam logic [CTRL_W-1:0] POWER_OFF_CTRL  = 8'h04;

	typedef enum logic [1:0] {
		OP_SET_FREQ  = 2'd0,
		OP_LOAD_WORD = 2'd1,
		OP_POWER_OFF = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REF_CLOCK = 2'd0,
		CFG_CONTROL   = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		op_t                   op;
		logic [VALUE_BITS-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic serial_bit;
		logic update_strobe;
		logic last;
	} res_t;

	// Item inside the divider pipeline; word ends up as the tuning word.
	typedef struct packed {
		op_t                   op;
		logic [CTRL_W-1:0]     ctrl;
		logic [REF_W-1:0]      rem;
		logic [VALUE_BITS-1:0] word;
	} div_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dds_tuning_word_serial_loader_core.sv -----
`default_nettype none
// Serial loader for a DDS 40-bit frequency/control word.
// Command channel (cmd_valid/cmd_stall, cmd): op and 32-bit value. Set frequency
// turns hertz into floor(value * 2^32 / ref_clock_hz) modulo 2^32; load word
// sends the value as is; power off sends a zero word with control byte 0x04.
// An unused op code is taken and dropped without results.
// Result channel (res_valid/res_stall, res): 41 results per command, 32 word
// bits then 8 control bits, LSB first, then one update strobe with last set.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
// reference clock, index 1 the control byte; writes are always taken.
// Commands pass through the 16-stage divider (four quotient bits per stage)
// and then load into the serializer, which sends one bit per cycle unless
// the receiver stalls, and takes the next command as the closing result of
// the current run leaves; the divider holds up to 16 further commands meanwhile.
// Reset restores the reference clock to 125 MHz and the control byte to zero,
// and empties the pipeline. A stalled receiver freezes the current result and
// the divider backs up stage by stage; nothing is lost or repeated.
`include "dds_tuning_word_serial_loader_core_defines.svh"

module dds_tuning_word_serial_loader_core import dtwsl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REF_W-1:0]     cfg_data
);

	logic [REF_W-1:0]  ref_clock_q;
	logic [CTRL_W-1:0] control_q;

	logic      s_valid [DIV_STAGES+1];
	div_item_t s_item  [DIV_STAGES+1];
	logic      s_stall [DIV_STAGES+1];

	logic      op_known;
	div_item_t entry_item;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clock_q <= REF_CLOCK_RESET;
			control_q   <= CONTROL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REF_CLOCK: ref_clock_q <= cfg_data;
				CFG_CONTROL:   control_q   <= cfg_data[CTRL_W-1:0];
				default:       ;
			endcase
		end
	end

	// Command entry: pick the control byte and seed the divider.
	assign op_known = (cmd.op == OP_SET_FREQ) || (cmd.op == OP_LOAD_WORD) ||
			(cmd.op == OP_POWER_OFF);

	always_comb begin
		entry_item.op   = cmd.op;
		entry_item.rem  = '0;
		entry_item.ctrl = (cmd.op == OP_POWER_OFF) ? POWER_OFF_CTRL : control_q;
		entry_item.word = (cmd.op == OP_POWER_OFF) ? '0 : cmd.value;
	end

	assign s_valid[0] = cmd_valid && op_known;
	assign s_item[0]  = entry_item;
	assign cmd_stall  = s_stall[0];

	// Divider pipeline.
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		dtwsl_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_idx (STAGE_IDX_W'(i)),
			.divisor   (ref_clock_q),
			.up_valid  (s_valid[i]),
			.up_item   (s_item[i]),
			.up_stall  (s_stall[i]),
			.dn_valid  (s_valid[i+1]),
			.dn_item   (s_item[i+1]),
			.dn_stall  (s_stall[i+1])
		);
	end

	// Serial output.
	dtwsl_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (s_valid[DIV_STAGES]),
		.up_item   (s_item[DIV_STAGES]),
		.up_stall  (s_stall[DIV_STAGES]),
		.res_valid (res_valid),
		.res       (res),
		.res_stall (res_stall)
	);

	// A run never breaks between its data bits.
	`DTWSL_ASSERT_NEXT(a_run_unbroken, clk, arst_n, res_valid && !res_stall && !res.last, res_valid, "run broke before its closing result")
	// Two closing results never come back to back.
	`DTWSL_ASSERT_NEXT(a_single_close, clk, arst_n, res_valid && !res_stall && res.last, !res_valid || !res.last, "closing result repeated")
	// The command side stalls only behind a held first stage.
	`DTWSL_ASSERT_NOW(a_stall_cause, clk, arst_n, cmd_stall, s_valid[1], "command stalled with empty first stage")

endmodule

`default_nettype wire

// ----- hw/rtl/dtwsl_div_stage.sv -----
`default_nettype none

module dtwsl_div_stage import dtwsl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [STAGE_IDX_W-1:0] stage_idx,
	input  logic [REF_W-1:0]       divisor,
	input  logic                   up_valid,
	input  div_item_t              up_item,
	output logic                   up_stall,
	output logic                   dn_valid,
	output div_item_t              dn_item,
	input  logic                   dn_stall
);

	logic      valid_s1;
	div_item_t item_s1;
	div_item_t item_nxt;

	// Restoring division steps. The word register shifts dividend bits out at the top
	// and quotient bits in at the bottom; after the value's own bits, zeros are fed.
	always_comb begin
		logic [REF_W-1:0]      rem;
		logic [VALUE_BITS-1:0] w;
		logic [REF_W:0]        trial;
		logic [STEP_IDX_W-1:0] idx;
		logic                  feed;
		logic                  q;
		rem      = up_item.rem;
		w        = up_item.word;
		trial    = '0;
		q        = 1'b0;
		item_nxt = up_item;
		for (int j = 0; j < STEPS_PER_STAGE; j++) begin
			idx  = {stage_idx, j[STEP_SEL_W-1:0]};
			feed = (idx < VALUE_BITS) ? w[VALUE_BITS-1] : 1'b0;
			if (up_item.op == OP_SET_FREQ && idx < DIV_STEPS) begin
				trial = {rem, feed};
				q     = (trial >= {1'b0, divisor});
				if (q) begin
					rem = REF_W'(trial - {1'b0, divisor});
				end else begin
					rem = trial[REF_W-1:0];
				end
				w = {w[VALUE_BITS-2:0], q};
			end
		end
		item_nxt.rem  = rem;
		item_nxt.word = w;
	end

	assign up_stall = valid_s1 && dn_stall;
	assign dn_valid = valid_s1;
	assign dn_item  = item_s1;

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			item_s1 <= item_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dtwsl_serializer.sv -----
`default_nettype none

module dtwsl_serializer import dtwsl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	input  div_item_t up_item,
	output logic      up_stall,
	output logic      res_valid,
	output res_t      res,
	input  logic      res_stall
);

	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(RUN_LEN - 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SR_W-1:0]   sr_q;
	logic              closing;
	logic              advance;
	logic              done_now;
	logic              load;

	assign closing  = (cnt_q == LAST_IDX);
	assign advance  = busy_q && !res_stall;
	assign done_now = advance && closing;
	assign up_stall = busy_q && !done_now;
	assign load     = up_valid && !up_stall;

	// Result drive comes straight from registers.
	assign res_valid         = busy_q;
	assign res.serial_bit    = closing ? 1'b0 : sr_q[0];
	assign res.update_strobe = closing;
	assign res.last          = closing;

	// Run control: a new item loads as the closing result of the previous run leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (advance) begin
			if (closing) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Shift register: word bits first, then the control byte, LSB first.
	always_ff @(posedge clk) begin
		if (load) begin
			sr_q <= {up_item.ctrl, up_item.word};
		end else if (advance) begin
			sr_q <= {1'b0, sr_q[SR_W-1:1]};
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;
	import dtwsl_pkg::*;

	// Op code that the block takes and drops without results.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Register indexes with no register behind them.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int RUN_BITS     = 40;
	localparam int DRAIN_CYCLES = 40;
	localparam int QUIET_LIMIT  = 3000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 72;

	typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

	// One directed step: a register write or a command, with the tuning word
	// and control byte typed in where they are obvious.
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  cfg_sel;
		logic [REF_W-1:0]      cfg_val;
		logic [1:0]            op;
		logic [VALUE_BITS-1:0] value;
		bit                    known;
		logic [WORD_BITS-1:0]  word;
		logic [CTRL_W-1:0]     ctrl;
	} row_t;

	typedef struct {
		res_t        bits;
		int unsigned item;
		int unsigned pos;
	} want_t;

	localparam row_t DIRECTED [24] = '{
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_LOAD_WORD, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'h00},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_LOAD_WORD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'h00},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_POWER_OFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 8'h04},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_POWER_OFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'h04},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'd0,         1'b1, 32'h0000_0000, 8'h00},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'd1,         1'b1, 32'h0000_0022, 8'h00},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'd62500000,  1'b1, 32'h8000_0000, 8'h00},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'd125000000, 1'b1, 32'h0000_0000, 8'h00},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'hFFFF_FFFF, 1'b0, '0, '0},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_UNUSED,    32'h1234_5678, 1'b0, '0, '0},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_UNUSED,    32'hFFFF_FFFF, 1'b0, '0, '0},
		'{ROW_CFG, CFG_CONTROL,   31'h0000_00FF, OP_LOAD_WORD, '0, 1'b0, '0, '0},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_LOAD_WORD, 32'h5A5A_A5A5, 1'b1, 32'h5A5A_A5A5, 8'hFF},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_POWER_OFF, 32'h0000_0000, 1'b1, 32'h0000_0000, 8'h04},
		'{ROW_CFG, CFG_REF_CLOCK, 31'h0000_0000, OP_LOAD_WORD, '0, 1'b0, '0, '0},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 8'hFF},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF},
		'{ROW_CFG, CFG_REF_CLOCK, 31'h7FFF_FFFF, OP_LOAD_WORD, '0, 1'b0, '0, '0},
		'{ROW_CFG, CFG_CONTROL,   31'h0000_0000, OP_LOAD_WORD, '0, 1'b0, '0, '0},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'hFFFF_FFFF, 1'b0, '0, '0},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 8'h00},
		'{ROW_CFG, CFG_REF_CLOCK, 31'h0000_0001, OP_LOAD_WORD, '0, 1'b0, '0, '0},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_SET_FREQ,  32'd3,         1'b1, 32'h0000_0000, 8'h00},
		'{ROW_CMD, CFG_REF_CLOCK, '0, OP_LOAD_WORD, 32'h8000_0001, 1'b1, 32'h8000_0001, 8'h00}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_t                 cmd = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	res_t                 res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REF_W-1:0]     cfg_data = '0;

	// Register copies kept by the predictor.
	logic [REF_W-1:0]  ref_hz = REF_CLOCK_RESET;
	logic [CTRL_W-1:0] ctrl_byte = CONTROL_RESET;

	want_t       expected_bits [$];
	int unsigned items_sent = 0;
	int unsigned mismatches = 0;
	int unsigned quiet = 0;
	bit          steady = 1'b0;

	dds_tuning_word_serial_loader_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 30) $display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Hertz to tuning word: floor(hz * 2^32 / ref), wrapped to 32 bits.
	// A zero reference gives all ones, as the restoring divider does.
	function automatic logic [WORD_BITS-1:0] tuning_word(input logic [VALUE_BITS-1:0] hz,
			input logic [REF_W-1:0] refhz);
		logic [63:0] scaled;
		if (refhz == '0) return '1;
		scaled = {hz, {WORD_BITS{1'b0}}};
		return WORD_BITS'(scaled / 64'(refhz));
	endfunction

	// Drive one command item, wait until it is taken, then queue its serial run unless the op is unused.
	task automatic send_cmd(input logic [1:0] code, input logic [VALUE_BITS-1:0] val,
			input bit known, input logic [WORD_BITS-1:0] kword, input logic [CTRL_W-1:0] kctrl);
		cmd_t              c;
		res_t              r;
		logic [WORD_BITS-1:0] w;
		logic [CTRL_W-1:0] k;
		while (!steady && $urandom_range(99) < 13) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		c.op = op_t'(code);
		c.value = val;
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		items_sent++;
		if (code == OP_UNUSED) return;
		if (code == OP_POWER_OFF) begin
			w = '0;
			k = POWER_OFF_CTRL;
		end else if (code == OP_LOAD_WORD) begin
			w = val;
			k = ctrl_byte;
		end else begin
			w = tuning_word(val, ref_hz);
			k = ctrl_byte;
		end
		if (known) begin
			w = kword;
			k = kctrl;
		end
		for (int n = 0; n < RUN_BITS; n++) begin
			r.serial_bit = (n < WORD_BITS) ? w[n] : k[n - WORD_BITS];
			r.update_strobe = 1'b0;
			r.last = 1'b0;
			expected_bits.push_back('{r, items_sent, n});
		end
		r = '{serial_bit: 1'b0, update_strobe: 1'b1, last: 1'b1};
		expected_bits.push_back('{r, items_sent, RUN_BITS});
	endtask

	// Stop sending, let every expected result arrive, then let dropped items clear.
	task automatic settle();
		cmd_valid <= 1'b0;
		while (expected_bits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register; valid is left high so writes can go back to back.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_REF_CLOCK) ref_hz = data;
		else if (idx == CFG_CONTROL) ctrl_byte = data[CTRL_W-1:0];
	endtask

	// Values that reach the interesting corners of the conversion.
	function automatic logic [VALUE_BITS-1:0] pick_value(input logic [REF_W-1:0] refhz);
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return {1'b0, refhz};
			3: return VALUE_BITS'($urandom_range(1000));
			4, 5: begin
				if (refhz != '0) return VALUE_BITS'($urandom_range(refhz - 1));
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	// Result side: random stall, and each taken item checked against the oldest expectation.
	always @(posedge clk) begin
		want_t w;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_bits.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					w = expected_bits.pop_front();
					if (res.serial_bit !== w.bits.serial_bit)
						report_mismatch($sformatf("command %0d bit %0d serial_bit %b, want %b",
							w.item, w.pos, res.serial_bit, w.bits.serial_bit));
					if (res.update_strobe !== w.bits.update_strobe)
						report_mismatch($sformatf("command %0d bit %0d update_strobe %b, want %b",
							w.item, w.pos, res.update_strobe, w.bits.update_strobe));
					if (res.last !== w.bits.last)
						report_mismatch($sformatf("command %0d bit %0d last %b, want %b",
							w.item, w.pos, res.last, w.bits.last));
				end
			end
			res_stall <= !steady && ($urandom_range(99) < 13);
		end
	end

	// Watchdog: ends the run when no channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Stimulus: directed rows, then random phases under different register settings.
	initial begin
		logic [REF_W-1:0]      rf;
		logic [CTRL_W-1:0]     cb;
		logic [1:0]            code;
		int unsigned           taken;
		int unsigned           pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				settle();
				write_reg(DIRECTED[i].cfg_sel, DIRECTED[i].cfg_val);
				cfg_valid <= 1'b0;
			end else begin
				send_cmd(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].known,
					DIRECTED[i].word, DIRECTED[i].ctrl);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					rf = REF_CLOCK_RESET;
					cb = 8'h5A;
				end
				1: begin
					rf = 31'd1;
					cb = 8'hFF;
				end
				2: begin
					rf = '1;
					cb = 8'h00;
				end
				3: begin
					rf = '0;
					cb = CTRL_W'($urandom);
				end
				4: begin
					rf = REF_W'($urandom_range(31'h7FFF_FFFF, 1));
					cb = CTRL_W'($urandom);
				end
				default: begin
					rf = REF_W'($urandom_range(200000000, 1000));
					cb = CTRL_W'($urandom);
				end
			endcase
			// One phase runs with no idling on either side.
			steady = (p == 2);
			settle();
			write_reg(CFG_REF_CLOCK, rf);
			write_reg(CFG_CONTROL, REF_W'(cb));
			write_reg(p[0] ? CFG_SPARE_B : CFG_SPARE_A, REF_W'($urandom));
			cfg_valid <= 1'b0;

			taken = 0;
			while (taken < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 45) code = OP_SET_FREQ;
				else if (pick < 70) code = OP_LOAD_WORD;
				else if (pick < 85) code = OP_POWER_OFF;
				else code = OP_UNUSED;
				send_cmd(code, pick_value(ref_hz), 1'b0, '0, '0);
				taken++;
			end
		end

		settle();
		if (mismatches == 0 && expected_bits.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
